>>> design/hta_pkg.sv
// Package for the handle table allocator.
// Holds the request and status codes and the write-control struct.
// No dependencies.
`default_nettype none

package hta_pkg;

  localparam int HANDLE_W = 16;
  localparam int WORD_W   = 64;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_GET   = 2'd2,
    REQ_SET   = 2'd3
  } hta_req_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } hta_status_e;

  // Write controls from execute logic to the slot and stack memories.
  typedef struct packed {
    logic obj_we;
    logic valid_we;
    logic valid_wd;
    logic stk_we;
  } hta_wr_t;

endpackage

`default_nettype wire

>>> design/hta_store.sv
// Slot memories (object words, valid marks) and the free-slot stack.
// Registered reads with forwarding of a write made at the same edge.
// Depends on hta_pkg.
`default_nettype none

module hta_store #(
  parameter int CAPACITY = 64,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  wire logic                         clk_i,
  input  wire logic                         rd_en_i,
  input  wire logic [IW-1:0]                rd_slot_i,
  input  wire logic [IW-1:0]                stk_rd_addr_i,
  input  wire hta_pkg::hta_wr_t             wr_i,
  input  wire logic [IW-1:0]                wr_slot_i,
  input  wire logic [hta_pkg::WORD_W-1:0]   wr_word_i,
  input  wire logic [IW-1:0]                stk_wr_addr_i,
  input  wire logic [IW-1:0]                stk_wd_i,
  output logic      [hta_pkg::WORD_W-1:0]   rd_obj_o,
  output logic                              rd_valid_o,
  output logic      [IW-1:0]                rd_stk_o
);

  logic [hta_pkg::WORD_W-1:0] obj_mem   [CAPACITY];
  logic                       valid_mem [CAPACITY];
  logic [IW-1:0]              stk_mem   [CAPACITY];

  logic [hta_pkg::WORD_W-1:0] rd_obj_q;
  logic                       rd_valid_q;
  logic [IW-1:0]              rd_stk_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.obj_we) begin
      obj_mem[wr_slot_i] <= wr_word_i;
    end
    if (wr_i.valid_we) begin
      valid_mem[wr_slot_i] <= wr_i.valid_wd;
    end
    if (wr_i.stk_we) begin
      stk_mem[stk_wr_addr_i] <= stk_wd_i;
    end
  end

  // The item ahead writes at the same edge this item reads, so a hit on
  // its address takes the new value instead of the old memory content.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_i.obj_we && (wr_slot_i == rd_slot_i)) begin
        rd_obj_q <= wr_word_i;
      end else begin
        rd_obj_q <= obj_mem[rd_slot_i];
      end
      if (wr_i.valid_we && (wr_slot_i == rd_slot_i)) begin
        rd_valid_q <= wr_i.valid_wd;
      end else begin
        rd_valid_q <= valid_mem[rd_slot_i];
      end
      if (wr_i.stk_we && (stk_wr_addr_i == stk_rd_addr_i)) begin
        rd_stk_q <= stk_wd_i;
      end else begin
        rd_stk_q <= stk_mem[stk_rd_addr_i];
      end
    end
  end

  assign rd_obj_o   = rd_obj_q;
  assign rd_valid_o = rd_valid_q;
  assign rd_stk_o   = rd_stk_q;

endmodule

`default_nettype wire

>>> design/hta_exec.sv
// Execute logic for one request: handle decode, range check, allocation
// choice, free-count and high-water registers, result fields.
// Depends on hta_pkg.
`default_nettype none

module hta_exec #(
  parameter int CAPACITY = 64,
  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           fire_i,
  input  wire logic [1:0]                     req_i,
  input  wire logic [hta_pkg::HANDLE_W-1:0]   handle_i,
  input  wire logic [hta_pkg::WORD_W-1:0]     rd_obj_i,
  input  wire logic                           rd_valid_i,
  input  wire logic [IW-1:0]                  rd_stk_i,
  output hta_pkg::hta_wr_t                    wr_o,
  output logic      [IW-1:0]                  wr_slot_o,
  output logic      [IW-1:0]                  stk_wr_addr_o,
  output logic      [IW-1:0]                  stk_wd_o,
  output logic      [CW-1:0]                  fc_next_o,
  output logic      [hta_pkg::HANDLE_W-1:0]   new_handle_o,
  output logic      [hta_pkg::WORD_W-1:0]     object_out_o,
  output logic                                is_valid_o,
  output hta_pkg::hta_status_e                status_o
);

  logic [CW-1:0] fc_q, fc_d;
  logic [CW-1:0] hw_q, hw_d;

  logic [14:0]   h_idx;
  logic [14:0]   slot_w;
  logic [IW-1:0] slot_idx;
  logic          in_range;
  logic          pop;
  logic          fresh_ok;
  logic [IW-1:0] alloc_slot;
  logic [15:0]   slot_p1;

  assign h_idx    = handle_i[15:1];
  assign slot_w   = h_idx - 15'd1;
  assign slot_idx = slot_w[IW-1:0];
  assign in_range = (h_idx != 15'd0) && ({1'b0, slot_w} < 16'(hw_q));

  assign pop        = (fc_q != '0);
  assign fresh_ok   = (hw_q < CW'(CAPACITY));
  assign alloc_slot = pop ? rd_stk_i : hw_q[IW-1:0];
  assign slot_p1    = 16'(alloc_slot) + 16'd1;

  always_comb begin
    fc_d          = fc_q;
    hw_d          = hw_q;
    wr_o          = '0;
    wr_slot_o     = slot_idx;
    stk_wr_addr_o = fc_q[IW-1:0];
    stk_wd_o      = slot_idx;
    new_handle_o  = '0;
    object_out_o  = '0;
    is_valid_o    = 1'b0;
    status_o      = hta_pkg::ST_OK;
    case (hta_pkg::hta_req_e'(req_i))
      hta_pkg::REQ_ALLOC: begin
        if (pop || fresh_ok) begin
          wr_o.obj_we   = 1'b1;
          wr_o.valid_we = 1'b1;
          wr_o.valid_wd = 1'b1;
          wr_slot_o     = alloc_slot;
          new_handle_o  = {slot_p1[14:0], 1'b0};
          if (pop) begin
            fc_d = fc_q - CW'(1);
          end else begin
            hw_d = hw_q + CW'(1);
          end
        end else begin
          status_o = hta_pkg::ST_FULL;
        end
      end
      hta_pkg::REQ_FREE: begin
        if (!in_range) begin
          status_o = hta_pkg::ST_RANGE;
        end else if (rd_valid_i && (fc_q < CW'(CAPACITY))) begin
          wr_o.valid_we = 1'b1;
          wr_o.stk_we   = 1'b1;
          fc_d          = fc_q + CW'(1);
        end
      end
      hta_pkg::REQ_GET: begin
        if (!in_range) begin
          status_o = hta_pkg::ST_RANGE;
        end else if (rd_valid_i) begin
          object_out_o = rd_obj_i;
          is_valid_o   = 1'b1;
        end
      end
      hta_pkg::REQ_SET: begin
        if (!in_range) begin
          status_o = hta_pkg::ST_RANGE;
        end else if (rd_valid_i) begin
          wr_o.obj_we = 1'b1;
        end
      end
      default: begin
        status_o = hta_pkg::ST_OK;
      end
    endcase
    // Nothing is written and no count moves unless the item leaves the stage.
    if (!fire_i) begin
      wr_o = '0;
      fc_d = fc_q;
      hw_d = hw_q;
    end
  end

  assign fc_next_o = fc_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q <= '0;
      hw_q <= '0;
    end else begin
      fc_q <= fc_d;
      hw_q <= hw_d;
    end
  end

endmodule

`default_nettype wire

>>> design/handle_table_allocator_top.sv
// Top level of the handle table allocator: input stage, execute logic,
// slot and stack memories, result register.
// Depends on hta_pkg, hta_exec and hta_store.
//
// The block takes one request per cycle while no result stalls, and answers
// each with exactly one result item, in order. An accepted item waits in the
// input stage register and is executed there; its result item is registered
// and offered once it fires. The rate of one item per
// cycle is set by the single execute stage that sits between the registered
// memory reads and the result register; a stalled result holds that stage
// and then the input. Reads for the next item start at its acceptance and
// take the value written by the item ahead at the same edge. Slots below the
// high-water mark have always been written, so the memories need no clearing
// pass after reset and requests are taken from the first cycle on.
`default_nettype none

module handle_table_allocator_top #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [1:0]                    in_req_type_i,
  input  wire logic [hta_pkg::HANDLE_W-1:0]  in_handle_i,
  input  wire logic [hta_pkg::WORD_W-1:0]    in_object_word_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [hta_pkg::HANDLE_W-1:0]  out_new_handle_o,
  output logic      [hta_pkg::WORD_W-1:0]    out_object_out_o,
  output logic                               out_is_valid_o,
  output logic      [1:0]                    out_status_o
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic                         x_valid_q;
  logic [1:0]                   x_req_q;
  logic [hta_pkg::HANDLE_W-1:0] x_handle_q;
  logic [hta_pkg::WORD_W-1:0]   x_word_q;

  logic                         out_valid_q;
  logic [hta_pkg::HANDLE_W-1:0] out_handle_q;
  logic [hta_pkg::WORD_W-1:0]   out_obj_q;
  logic                         out_isv_q;
  logic [1:0]                   out_status_q;

  logic advance;
  logic fire;
  logic accept;

  hta_pkg::hta_wr_t             wr;
  logic [IW-1:0]                wr_slot;
  logic [IW-1:0]                stk_wr_addr;
  logic [IW-1:0]                stk_wd;
  logic [CW-1:0]                fc_next;
  logic [CW-1:0]                stk_top;
  logic [14:0]                  in_slot_w;
  logic [hta_pkg::WORD_W-1:0]   rd_obj;
  logic                         rd_valid;
  logic [IW-1:0]                rd_stk;
  logic [hta_pkg::HANDLE_W-1:0] res_handle;
  logic [hta_pkg::WORD_W-1:0]   res_obj;
  logic                         res_isv;
  hta_pkg::hta_status_e         res_status;

  assign advance    = !out_valid_q || !out_stall_i;
  assign fire       = x_valid_q && advance;
  assign in_stall_o = x_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // Read addresses for the item being accepted: its decoded slot, and the
  // stack top as it stands once the item ahead has been executed.
  assign in_slot_w = in_handle_i[15:1] - 15'd1;
  assign stk_top   = fc_next - CW'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_valid_q <= 1'b0;
    end else if (accept) begin
      x_valid_q <= 1'b1;
    end else if (fire) begin
      x_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_req_q    <= in_req_type_i;
      x_handle_q <= in_handle_i;
      x_word_q   <= in_object_word_i;
    end
  end

  hta_exec #(
    .CAPACITY(CAPACITY)
  ) u_exec (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (fire),
    .req_i         (x_req_q),
    .handle_i      (x_handle_q),
    .rd_obj_i      (rd_obj),
    .rd_valid_i    (rd_valid),
    .rd_stk_i      (rd_stk),
    .wr_o          (wr),
    .wr_slot_o     (wr_slot),
    .stk_wr_addr_o (stk_wr_addr),
    .stk_wd_o      (stk_wd),
    .fc_next_o     (fc_next),
    .new_handle_o  (res_handle),
    .object_out_o  (res_obj),
    .is_valid_o    (res_isv),
    .status_o      (res_status)
  );

  hta_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk_i         (clk_i),
    .rd_en_i       (accept),
    .rd_slot_i     (in_slot_w[IW-1:0]),
    .stk_rd_addr_i (stk_top[IW-1:0]),
    .wr_i          (wr),
    .wr_slot_i     (wr_slot),
    .wr_word_i     (x_word_q),
    .stk_wr_addr_i (stk_wr_addr),
    .stk_wd_i      (stk_wd),
    .rd_obj_o      (rd_obj),
    .rd_valid_o    (rd_valid),
    .rd_stk_o      (rd_stk)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= x_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_handle_q <= res_handle;
      out_obj_q    <= res_obj;
      out_isv_q    <= res_isv;
      out_status_q <= res_status;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_new_handle_o = out_handle_q;
  assign out_object_out_o = out_obj_q;
  assign out_is_valid_o   = out_isv_q;
  assign out_status_o     = out_status_q;

endmodule

`default_nettype wire

>>> design/hta_checker.sv
// Port-level checks for the handle table allocator, bound to its top level.
// Depends on hta_pkg and handle_table_allocator_top.
`default_nettype none

module hta_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [hta_pkg::HANDLE_W-1:0]  out_new_handle_o,
  input wire logic [hta_pkg::WORD_W-1:0]    out_object_out_o,
  input wire logic                          out_is_valid_o,
  input wire logic [1:0]                    out_status_o
);

  // A stalled result item holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_new_handle_o)
      && $stable(out_object_out_o) && $stable(out_status_o))
    else $error("stalled result item changed");

  // Any error status leaves every other result field zero.
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o != hta_pkg::ST_OK) |->
      (out_new_handle_o == '0) && (out_object_out_o == '0) && !out_is_valid_o)
    else $error("error result carries data");

  // Handles handed out are always even, and a valid get carries no new handle.
  a_handle_even: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !out_new_handle_o[0]
      && (!out_is_valid_o || (out_new_handle_o == '0)))
    else $error("bad handle in result item");

  // A result item that rises on an empty result side had its request accepted
  // at the edge before the one that registered it.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && !in_stall_o, 2))
    else $error("result item without a request");

endmodule

bind handle_table_allocator_top hta_checker u_hta_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .out_new_handle_o (out_new_handle_o),
  .out_object_out_o (out_object_out_o),
  .out_is_valid_o   (out_is_valid_o),
  .out_status_o     (out_status_o)
);

`default_nettype wire
